@@ design/csmd_pkg.sv @@
package csmd_pkg;

   localparam int unsigned WordWidth    = 32;
   localparam int unsigned AddressWidth = 16;
   localparam int unsigned SubWidth     = 3;
   localparam int unsigned CountWidth   = 13;
   localparam int unsigned NopWidth     = 16;
   localparam int unsigned NumSubs      = 8;

   localparam logic [2:0] ModeNoIncrement = 3'd3;
   localparam logic [2:0] ModeImmediate   = 3'd4;
   localparam logic [2:0] ModeSingleStep  = 3'd5;

   typedef enum logic [2:0] {
      KIND_OFF_WINDOW  = 3'd0,
      KIND_SKIPPED     = 3'd1,
      KIND_HEADER      = 3'd2,
      KIND_DATA        = 3'd3,
      KIND_IMMEDIATE   = 3'd4,
      KIND_JUMP        = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      CLS_HEADER    = 2'd0,
      CLS_IMMEDIATE = 2'd1,
      CLS_JUMP      = 2'd2
   } cls_type;

   typedef struct packed {
      logic [WordWidth-1:0]    word;
      logic                    off_window;
      logic                    zero;
      cls_type                 cls;
      logic [AddressWidth-1:0] address;
      logic [SubWidth-1:0]     subchannel;
      logic [CountWidth-1:0]   count;
      logic [CountWidth-1:0]   budget;
   } item_type;

   typedef struct packed {
      kind_type                kind;
      logic [AddressWidth-1:0] method_address;
      logic [SubWidth-1:0]     subchannel;
      logic [WordWidth-1:0]    value;
      logic [CountWidth-1:0]   data_count;
      logic [CountWidth-1:0]   increment_budget;
      logic [NopWidth-1:0]     nops_before;
      logic [WordWidth-1:0]    bound_handle;
   } result_type;

   typedef struct packed {
      logic valid;
      item_type item;
   } front_out_type;

endpackage

@@ design/csmd_front.sv @@
module csmd_front
   import csmd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 new_header_format,
   input  logic                 push,
   output logic                 full,
   input  logic [WordWidth-1:0] word,
   input  logic                 off_window,
   output front_out_type        head,
   input  logic                 take
);

   item_type   decoded;
   logic [2:0] mode;

   item_type   mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   // Header fields depend only on the word and the layout, so they are
   // extracted before the item is queued.
   always_comb begin
      mode = word[31:29];
      decoded.word        = word;
      decoded.off_window  = off_window;
      decoded.zero        = (word == '0);
      decoded.subchannel  = word[15:13];
      if (new_header_format) begin
         decoded.address = {1'b0, word[12:0], 2'b00};
         decoded.count   = word[28:16];
         if (mode == ModeImmediate) begin
            decoded.cls = CLS_IMMEDIATE;
         end else begin
            decoded.cls = CLS_HEADER;
         end
         priority if (mode == ModeNoIncrement) begin
            decoded.budget = '0;
         end else if (mode == ModeSingleStep) begin
            decoded.budget = CountWidth'(1);
         end else begin
            decoded.budget = word[28:16];
         end
      end else begin
         decoded.address = {3'b000, word[12:0]};
         decoded.count   = {2'b00, word[28:18]};
         if (word[29]) begin
            decoded.cls = CLS_JUMP;
         end else begin
            decoded.cls = CLS_HEADER;
         end
         if (word[30]) begin
            decoded.budget = '0;
         end else begin
            decoded.budget = {2'b00, word[28:18]};
         end
      end
   end

   assign full       = (count_ff == 2'd2);
   assign do_push    = push && !full;
   assign do_pop     = take && (count_ff != 2'd0);
   assign head.valid = (count_ff != 2'd0);
   assign head.item  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= decoded;
      end
   end

   a_front_count: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("front queue count out of range");

endmodule

@@ design/csmd_out_queue.sv @@
module csmd_out_queue
   import csmd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       full,
   output logic       empty,
   input  logic       pop,
   output result_type head
);

   result_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_out_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("result pushed into a full queue");

endmodule

@@ design/csmd_back.sv @@
module csmd_back
   import csmd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  front_out_type head,
   output logic          take,
   input  logic          out_full,
   output logic          res_push,
   output result_type    res
);

   logic [CountWidth-1:0]   words_left_ff, words_left_in;
   logic [CountWidth-1:0]   increments_left_ff, increments_left_in;
   logic [AddressWidth-1:0] address_ff, address_in;
   logic [SubWidth-1:0]     subchannel_ff, subchannel_in;
   logic                    skip_pending_ff, skip_pending_in;
   logic [NopWidth-1:0]     nop_counter_ff, nop_counter_in;
   logic [WordWidth-1:0]    handles_ff [NumSubs];

   item_type             it;
   logic                 bind_en;
   logic [WordWidth-1:0] cur_handle;
   logic [WordWidth-1:0] hdr_handle;

   assign it         = head.item;
   assign take       = head.valid && !out_full;
   assign cur_handle = handles_ff[subchannel_ff];
   assign hdr_handle = handles_ff[it.subchannel];

   always_comb begin
      words_left_in      = words_left_ff;
      increments_left_in = increments_left_ff;
      address_in         = address_ff;
      subchannel_in      = subchannel_ff;
      skip_pending_in    = skip_pending_ff;
      nop_counter_in     = nop_counter_ff;
      bind_en            = 1'b0;
      res_push           = 1'b0;

      res.kind             = KIND_OFF_WINDOW;
      res.method_address   = address_ff;
      res.subchannel       = subchannel_ff;
      res.value            = it.word;
      res.data_count       = '0;
      res.increment_budget = '0;
      res.nops_before      = '0;
      res.bound_handle     = cur_handle;

      if (take) begin
         priority if (it.off_window) begin
            res_push = 1'b1;
         end else if (skip_pending_ff) begin
            res_push        = 1'b1;
            res.kind        = KIND_SKIPPED;
            skip_pending_in = 1'b0;
         end else if (words_left_ff != '0) begin
            res_push             = 1'b1;
            res.kind             = KIND_DATA;
            res.data_count       = words_left_ff;
            res.increment_budget = increments_left_ff;
            if (address_ff == '0) begin
               bind_en          = 1'b1;
               res.bound_handle = it.word;
            end
            if (increments_left_ff != '0) begin
               address_in         = address_ff + AddressWidth'(4);
               increments_left_in = increments_left_ff - CountWidth'(1);
            end
            words_left_in = words_left_ff - CountWidth'(1);
         end else if (it.zero) begin
            if (nop_counter_ff != '1) begin
               nop_counter_in = nop_counter_ff + NopWidth'(1);
            end
         end else begin
            res_push        = 1'b1;
            res.nops_before = nop_counter_ff;
            nop_counter_in  = '0;
            unique case (it.cls)
               CLS_JUMP: begin
                  res.kind        = KIND_JUMP;
                  res.value       = {3'b000, it.word[28:0]};
                  skip_pending_in = 1'b1;
               end
               CLS_IMMEDIATE: begin
                  res.kind           = KIND_IMMEDIATE;
                  res.method_address = it.address;
                  res.subchannel     = it.subchannel;
                  res.value          = {{(WordWidth-CountWidth){1'b0}}, it.count};
                  res.bound_handle   = hdr_handle;
                  address_in         = it.address;
                  subchannel_in      = it.subchannel;
                  words_left_in      = '0;
                  increments_left_in = it.budget;
               end
               CLS_HEADER: begin
                  res.kind             = KIND_HEADER;
                  res.method_address   = it.address;
                  res.subchannel       = it.subchannel;
                  res.data_count       = it.count;
                  res.increment_budget = it.budget;
                  res.bound_handle     = hdr_handle;
                  address_in           = it.address;
                  subchannel_in        = it.subchannel;
                  words_left_in        = it.count;
                  increments_left_in   = it.budget;
               end
               default: begin
                  res_push = 1'b0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         words_left_ff      <= '0;
         increments_left_ff <= '0;
         address_ff         <= '0;
         subchannel_ff      <= '0;
         skip_pending_ff    <= 1'b0;
         nop_counter_ff     <= '0;
         for (int i = 0; i < NumSubs; i++) begin
            handles_ff[i] <= '0;
         end
      end else begin
         words_left_ff      <= words_left_in;
         increments_left_ff <= increments_left_in;
         address_ff         <= address_in;
         subchannel_ff      <= subchannel_in;
         skip_pending_ff    <= skip_pending_in;
         nop_counter_ff     <= nop_counter_in;
         if (bind_en) begin
            handles_ff[subchannel_ff] <= it.word;
         end
      end
   end

   a_skip_clears: assert property (@(posedge clock) disable iff (reset)
      (take && skip_pending_ff && !it.off_window) |=> !skip_pending_ff)
      else $error("skip pending not cleared by a skipped word");

   a_data_keeps_nops: assert property (@(posedge clock) disable iff (reset)
      (take && !it.off_window && !skip_pending_ff && words_left_ff != '0)
      |=> $stable(nop_counter_ff))
      else $error("NOP count changed on a data word");

   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      res_push |-> (take && !out_full))
      else $error("result produced without an accepted request");

endmodule

@@ design/command_stream_method_decoder_core.sv @@
// Channel   Handshake              Payload
// req_      req_push / req_full    req_word, req_off_window
// rsp_      rsp_pop / rsp_empty    rsp_kind .. rsp_bound_handle
// csr_      csr_valid / csr_ready  csr_new_header_format
//
// One request is accepted per cycle while req_full is low; a request is stored in
// the request queue, and any result it yields is stored in the result queue
// before it is on the rsp_ ports. The rate is set by the back-end state update.
// Synchronous reset clears both queues, the decoder state and all handles.
// A stall on the rsp_ side fills the result queue and then the request queue;
// req_full is high while the request queue holds two requests.
module command_stream_method_decoder_core
   import csmd_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  logic [WordWidth-1:0]    req_word,
   input  logic                    req_off_window,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output logic [2:0]              rsp_kind,
   output logic [AddressWidth-1:0] rsp_method_address,
   output logic [SubWidth-1:0]     rsp_subchannel,
   output logic [WordWidth-1:0]    rsp_value,
   output logic [CountWidth-1:0]   rsp_data_count,
   output logic [CountWidth-1:0]   rsp_increment_budget,
   output logic [NopWidth-1:0]     rsp_nops_before,
   output logic [WordWidth-1:0]    rsp_bound_handle,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic                    csr_new_header_format
);

   logic          new_header_format_ff, new_header_format_in;
   front_out_type front_head;
   logic          take;
   logic          out_full;
   logic          res_push;
   result_type    res;
   result_type    rsp_head;

   assign csr_ready = 1'b1;

   always_comb begin
      new_header_format_in = new_header_format_ff;
      if (csr_valid && csr_ready) begin
         new_header_format_in = csr_new_header_format;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         new_header_format_ff <= 1'b0;
      end else begin
         new_header_format_ff <= new_header_format_in;
      end
   end

   csmd_front u_front (
      .clock             (clock),
      .reset             (reset),
      .new_header_format (new_header_format_ff),
      .push              (req_push),
      .full              (req_full),
      .word              (req_word),
      .off_window        (req_off_window),
      .head              (front_head),
      .take              (take)
   );

   csmd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (front_head),
      .take     (take),
      .out_full (out_full),
      .res_push (res_push),
      .res      (res)
   );

   csmd_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res),
      .full      (out_full),
      .empty     (rsp_empty),
      .pop       (rsp_pop),
      .head      (rsp_head)
   );

   assign rsp_kind             = rsp_head.kind;
   assign rsp_method_address   = rsp_head.method_address;
   assign rsp_subchannel       = rsp_head.subchannel;
   assign rsp_value            = rsp_head.value;
   assign rsp_data_count       = rsp_head.data_count;
   assign rsp_increment_budget = rsp_head.increment_budget;
   assign rsp_nops_before      = rsp_head.nops_before;
   assign rsp_bound_handle     = rsp_head.bound_handle;

endmodule
